@@ design/daac_pkg.sv @@
`timescale 1ns / 1ps

package daac_pkg;

	localparam int REG_COUNT = 16;
	localparam int RF_IDX_W  = 4;
	localparam int WORD_W    = 32;

	localparam logic [RF_IDX_W-1:0] REG_SP = 4'd13;
	localparam logic [RF_IDX_W-1:0] REG_PC = 4'd15;

	// Thumb opcode patterns
	localparam logic [15:0] THUMB_PCREL_MASK   = 16'hF800;
	localparam logic [15:0] THUMB_PCREL_CODE   = 16'h4800;
	localparam logic [15:0] THUMB_PUSHPOP_MASK = 16'hF700;
	localparam logic [15:0] THUMB_PUSHPOP_CODE = 16'hB500;
	localparam logic [3:0]  THUMB_REGOFS_TOP   = 4'h5;
	localparam logic [2:0]  THUMB_IMMOFS_TOP3  = 3'b011;
	localparam logic [3:0]  THUMB_HALFIMM_TOP  = 4'h8;
	localparam logic [3:0]  THUMB_SPREL_TOP    = 4'h9;
	localparam logic [3:0]  THUMB_MULTI_TOP    = 4'hC;

	// ARM opcode patterns
	localparam logic [31:0] ARM_SWP_MASK      = 32'h0FB00FF0;
	localparam logic [31:0] ARM_SWP_CODE      = 32'h01000090;
	localparam logic [31:0] ARM_SDT_MASK      = 32'h0C000000;
	localparam logic [31:0] ARM_SDT_CODE      = 32'h04000000;
	localparam logic [31:0] ARM_HALF_MASK     = 32'h0E400F90;
	localparam logic [31:0] ARM_HALF_REG_CODE = 32'h00000090;
	localparam logic [31:0] ARM_HALF_IMM_CODE = 32'h00400090;
	localparam logic [31:0] ARM_BDT_MASK      = 32'h0E000000;
	localparam logic [31:0] ARM_BDT_CODE      = 32'h08000000;
	localparam int          ARM_UP_BIT        = 23;
	localparam int          ARM_PRE_BIT       = 24;
	localparam int          ARM_REGOFS_BIT    = 25;

	// Shift byte that leaves the offset register untouched.
	localparam logic [7:0] SHIFT_PASS = 8'h0B;

	typedef enum logic [2:0] {
		TH_PC_REL,
		TH_REG_OFS,
		TH_IMM_OFS,
		TH_SP_REL,
		TH_PUSH_POP,
		TH_MULTI,
		TH_NONE
	} thumb_class_t;

	typedef enum logic [1:0] {
		SH_LSL,
		SH_LSR,
		SH_ASR,
		SH_ROR
	} shift_kind_t;

	typedef struct packed {
		logic [RF_IDX_W-1:0] base;
		logic [RF_IDX_W-1:0] ofs;
		logic [RF_IDX_W-1:0] shf;
	} rf_addr_t;

	typedef struct packed {
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] ofs;
		logic [WORD_W-1:0] shf;
	} rf_read_t;

	function automatic thumb_class_t thumb_class(input logic [15:0] op);
		thumb_class_t cls;
		if ((op & THUMB_PCREL_MASK) == THUMB_PCREL_CODE) begin
			cls = TH_PC_REL;
		end else if (op[15:12] == THUMB_REGOFS_TOP) begin
			cls = TH_REG_OFS;
		end else if (op[15:13] == THUMB_IMMOFS_TOP3 || op[15:12] == THUMB_HALFIMM_TOP) begin
			cls = TH_IMM_OFS;
		end else if (op[15:12] == THUMB_SPREL_TOP) begin
			cls = TH_SP_REL;
		end else if ((op & THUMB_PUSHPOP_MASK) == THUMB_PUSHPOP_CODE) begin
			cls = TH_PUSH_POP;
		end else if (op[15:12] == THUMB_MULTI_TOP) begin
			cls = TH_MULTI;
		end else begin
			cls = TH_NONE;
		end
		return cls;
	endfunction

endpackage

@@ design/daac_ram.sv @@
`timescale 1ns / 1ps

module daac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

@@ design/daac_regfile.sv @@
`timescale 1ns / 1ps

module daac_regfile
	import daac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [RF_IDX_W-1:0] waddr,
	input  logic [WORD_W-1:0]   wdata,
	input  logic                re,
	input  rf_addr_t            raddr,
	output rf_read_t            rdata
);

	logic [REG_COUNT-1:0] valid_q;
	logic [2:0]           rd_vld_q;
	rf_read_t             ram_q;

	// Three copies written alike give three independent read ports.
	daac_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_ram_base (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr.base), .rdata(ram_q.base)
	);

	daac_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_ram_ofs (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr.ofs), .rdata(ram_q.ofs)
	);

	daac_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_ram_shf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr.shf), .rdata(ram_q.shf)
	);

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= '0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= {valid_q[raddr.base], valid_q[raddr.ofs], valid_q[raddr.shf]};
			end
		end
	end

	assign rdata.base = rd_vld_q[2] ? ram_q.base : '0;
	assign rdata.ofs  = rd_vld_q[1] ? ram_q.ofs  : '0;
	assign rdata.shf  = rd_vld_q[0] ? ram_q.shf  : '0;

endmodule

@@ design/daac_shifter.sv @@
`timescale 1ns / 1ps

module daac_shifter
	import daac_pkg::*;
(
	input  logic [WORD_W-1:0] value,
	input  logic [7:0]        sh,
	input  logic [7:0]        reg_amt,
	output logic [WORD_W-1:0] result
);

	logic [7:0]        amt;
	logic [4:0]        amt5;
	logic              big;
	logic [2*WORD_W-1:0] rot;
	shift_kind_t       kind;

	always_comb begin
		amt  = sh[0] ? reg_amt : {3'b000, sh[7:3]};
		amt5 = amt[4:0];
		big  = (amt[7:5] != 3'b000);
		kind = shift_kind_t'(sh[2:1]);
		rot  = {value, value} >> amt5;
		if (sh == SHIFT_PASS) begin
			result = value;
		end else begin
			case (kind)
				SH_LSL: result = big ? '0 : (value << amt5);
				SH_LSR: result = big ? '0 : (value >> amt5);
				SH_ASR: begin
					if (big) begin
						result = {WORD_W{value[WORD_W-1]}};
					end else begin
						result = $unsigned($signed(value) >>> amt5);
					end
				end
				SH_ROR: result = rot[WORD_W-1:0];
				default: result = value;
			endcase
		end
	end

endmodule

@@ design/daac_addr_calc.sv @@
`timescale 1ns / 1ps

module daac_addr_calc
	import daac_pkg::*;
(
	input  logic [WORD_W-1:0] instr,
	input  logic              thumb,
	input  rf_read_t          rf,
	output logic [WORD_W-1:0] addr,
	output logic              hit
);

	logic [WORD_W-1:0] shifted;
	logic [WORD_W-1:0] arm_ofs;
	logic [WORD_W-1:0] arm_sum;
	logic [WORD_W-1:0] sbyte;
	logic [WORD_W-1:0] th_addr;
	logic              th_hit;
	logic [WORD_W-1:0] arm_addr;
	logic              arm_hit;
	logic              use_base;
	thumb_class_t      cls;

	daac_shifter u_shifter (
		.value  (rf.ofs),
		.sh     (instr[11:4]),
		.reg_amt(rf.shf[7:0]),
		.result (shifted)
	);

	always_comb begin
		cls   = thumb_class(instr[15:0]);
		sbyte = {{(WORD_W-8){instr[7]}}, instr[7:0]};
		th_hit = 1'b1;
		case (cls)
			TH_PC_REL, TH_SP_REL: th_addr = rf.base + sbyte;
			TH_REG_OFS:           th_addr = rf.base + rf.ofs;
			TH_IMM_OFS:           th_addr = rf.base + {25'd0, instr[10:6], 2'b00};
			TH_PUSH_POP, TH_MULTI: th_addr = rf.base;
			default: begin
				th_addr = '0;
				th_hit  = 1'b0;
			end
		endcase
	end

	// One shared add/subtract serves every ARM offset form.
	always_comb begin
		arm_hit  = 1'b1;
		use_base = 1'b0;
		arm_ofs  = '0;
		if ((instr & ARM_SWP_MASK) == ARM_SWP_CODE) begin
			use_base = 1'b1;
		end else if ((instr & ARM_SDT_MASK) == ARM_SDT_CODE) begin
			if (!instr[ARM_PRE_BIT]) begin
				use_base = 1'b1;
			end else if (instr[ARM_REGOFS_BIT]) begin
				arm_ofs = shifted;
			end else begin
				arm_ofs = {20'd0, instr[11:0]};
			end
		end else if ((instr & ARM_HALF_MASK) == ARM_HALF_REG_CODE) begin
			arm_ofs = shifted;
		end else if ((instr & ARM_HALF_MASK) == ARM_HALF_IMM_CODE) begin
			arm_ofs = {24'd0, instr[11:8], instr[3:0]};
		end else if ((instr & ARM_BDT_MASK) == ARM_BDT_CODE) begin
			use_base = 1'b1;
		end else begin
			arm_hit = 1'b0;
		end
		arm_sum = instr[ARM_UP_BIT] ? (rf.base + arm_ofs) : (rf.base - arm_ofs);
		if (!arm_hit) begin
			arm_addr = '0;
		end else if (use_base) begin
			arm_addr = rf.base;
		end else begin
			arm_addr = arm_sum;
		end
	end

	assign addr = thumb ? th_addr : arm_addr;
	assign hit  = thumb ? th_hit  : arm_hit;

endmodule

@@ design/data_abort_address_calc_top.sv @@
// Load/store effective address unit.
// A compute transfer passes through stage 1 (register file read) and stage 2 (registered address).
// Throughput: one transfer per cycle unless out_stall holds the pipeline, set by the
// register file read and one decode/shift/add stage; a register write gives no result.
// Reset (arst_n low, asynchronous) empties the pipeline and marks all 16
// registers unwritten, so they read as zero; no clearing pass is needed.
`timescale 1ns / 1ps

module data_abort_address_calc_top
	import daac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [RF_IDX_W-1:0] reg_index,
	input  logic [WORD_W-1:0]   reg_value,
	input  logic [WORD_W-1:0]   instr_word,
	input  logic                thumb_state,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WORD_W-1:0]   fault_address,
	output logic                matched
);

	logic              valid_s1;
	logic [WORD_W-1:0] instr_s1;
	logic              thumb_s1;
	logic              valid_s2;
	logic [WORD_W-1:0] addr_s2;
	logic              hit_s2;

	logic              s1_ready;
	logic              s2_ready;
	logic              in_xfer;
	logic              rf_we;
	logic              rf_re;
	rf_addr_t          rf_addr;
	rf_read_t          rf_data;
	logic [WORD_W-1:0] calc_addr;
	logic              calc_hit;
	thumb_class_t      in_cls;

	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_stall = !s1_ready;
	assign in_xfer  = in_valid && s1_ready;
	assign rf_we    = in_xfer && !operation;
	assign rf_re    = in_xfer && operation;

	// Read addresses come from the incoming word so the data lands with stage 1.
	always_comb begin
		in_cls       = thumb_class(instr_word[15:0]);
		rf_addr.ofs  = thumb_state ? {1'b0, instr_word[8:6]} : instr_word[3:0];
		rf_addr.shf  = instr_word[11:8];
		if (!thumb_state) begin
			rf_addr.base = instr_word[19:16];
		end else begin
			case (in_cls)
				TH_PC_REL:             rf_addr.base = REG_PC;
				TH_SP_REL, TH_PUSH_POP: rf_addr.base = REG_SP;
				TH_MULTI:              rf_addr.base = {1'b0, instr_word[10:8]};
				default:               rf_addr.base = {1'b0, instr_word[5:3]};
			endcase
		end
	end

	daac_regfile u_regfile (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (rf_we),
		.waddr (reg_index),
		.wdata (reg_value),
		.re    (rf_re),
		.raddr (rf_addr),
		.rdata (rf_data)
	);

	daac_addr_calc u_addr_calc (
		.instr(instr_s1),
		.thumb(thumb_s1),
		.rf   (rf_data),
		.addr (calc_addr),
		.hit  (calc_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= rf_re;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rf_re) begin
			instr_s1 <= instr_word;
			thumb_s1 <= thumb_state;
		end
		if (s2_ready && valid_s1) begin
			addr_s2 <= calc_addr;
			hit_s2  <= calc_hit;
		end
	end

	assign out_valid     = valid_s2;
	assign fault_address = addr_s2;
	assign matched       = hit_s2;

`ifndef SYNTH
	a_compute_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation) |=> valid_s1)
		else $error("accepted compute transfer did not enter stage 1");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !operation && !valid_s1) |=> !valid_s1)
		else $error("register write produced a pipeline item");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && valid_s1) |=> (valid_s1 && $stable(instr_s1)))
		else $error("stage 1 changed while the output was stalled");

	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !matched) |-> (fault_address == '0))
		else $error("unmatched instruction gave a nonzero address");
`endif

endmodule
